@@ sv/jdha_pkg.sv @@
`default_nettype none
package jdha_pkg;

    localparam logic [1:0] FN_PACKET = 2'd0;
    localparam logic [1:0] FN_ALARM  = 2'd1;
    localparam logic [1:0] FN_TICK   = 2'd2;

    localparam logic [1:0] LVL_CLEAR   = 2'd0;
    localparam logic [1:0] LVL_SUSPECT = 2'd1;
    localparam logic [1:0] LVL_JAMMED  = 2'd2;

    localparam logic [2:0] REG_WIN_BY_TIME = 3'd0;
    localparam logic [2:0] REG_WIN_LEN     = 3'd1;
    localparam logic [2:0] REG_MIN_BAD     = 3'd2;
    localparam logic [2:0] REG_THRESHOLD   = 3'd3;
    localparam logic [2:0] REG_WINS_TO_JAM = 3'd4;
    localparam logic [2:0] REG_JAM_HOLD    = 3'd5;
    localparam logic [2:0] REG_RECO_GAP    = 3'd6;
    localparam logic [2:0] REG_GROUP_OK    = 3'd7;

    localparam logic [15:0] DFLT_WIN_LEN  = 16'd1000;
    localparam logic [15:0] DFLT_RECO_GAP = 16'd500;
    localparam logic [31:0] ALARM_AGE_CNT = 32'd1000;
    localparam logic [6:0]  PCT_MAX       = 7'd100;
    localparam logic [6:0]  ALARM_BONUS   = 7'd10;
    localparam logic [6:0]  GROUP_SCORE   = 7'd80;
    localparam logic [7:0]  STREAK_MAX    = 8'd255;
    // x/100 == (x*5243)>>19 for x below 43690
    localparam logic [12:0] RECIP_100     = 13'd5243;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    function automatic logic [6:0] eff_thr(input logic [6:0] t);
        if (t == 7'd0) return 7'd1;
        if (t > PCT_MAX) return PCT_MAX;
        return t;
    endfunction

    function automatic logic [6:0] score_of(input logic [6:0] pct, input logic alarm,
                                            input logic nonempty);
        logic [7:0] s;
        s = {1'b0, pct} + (alarm ? {1'b0, ALARM_BONUS} : 8'd0);
        if (!nonempty) return 7'd0;
        if (s > {1'b0, PCT_MAX}) return PCT_MAX;
        return s[6:0];
    endfunction

    function automatic logic [7:0] hint_of(input logic [6:0] score);
        logic [14:0] x;
        logic [27:0] p;
        x = {score, 8'd0} - {8'd0, score};
        p = {13'd0, x} * {15'd0, RECIP_100};
        return p[26:19];
    endfunction

endpackage
`default_nettype wire

@@ sv/jdha_ram.sv @@
`default_nettype none
module jdha_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ sv/jdha_div.sv @@
`default_nettype none
module jdha_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jdha_pkg::div_req_t req,
    output      jdha_pkg::div_rsp_t rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [31:0] rem_reg;
    logic [31:0] quot_reg;
    logic [31:0] dvsr_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quot_reg[31]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign take    = (shifted >= {1'b0, dvsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quot_reg <= req.dividend;
                dvsr_reg <= req.divisor;
            end else if (busy_reg) begin
                rem_reg  <= take ? diff[31:0] : shifted[31:0];
                quot_reg <= {quot_reg[30:0], take};
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

@@ sv/jamming_detector_hop_advisor_unit.sv @@
// the time from input beat to result beat is set by the shared bit-serial divider (32 steps
//   per use) and the read-then-compare prune walk; it grows with each pruned ring entry in
//   time mode, with the bound step when a window closes and with a tick's remainder division
// throughput: one event in work at a time; the next input beat is taken the cycle after the
//   result is registered, later while the previous result still waits in the output register
// reset (aresetn low, synchronous) clears counters, levels, times and flags; ring left as is
`default_nettype none
module jamming_detector_hop_advisor_unit #(
    parameter int WINDOW_PACKETS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic        s_packet_good,
    input  wire logic [31:0] s_time_ms,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [1:0]  m_link_state,
    output      logic [6:0]  m_score,
    output      logic [6:0]  m_confidence,
    output      logic [7:0]  m_aggressiveness,
    output      logic        m_hop_advice,
    output      logic        m_hop_fired,
    output      logic        m_group_switch,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    localparam int IDX_W = (WINDOW_PACKETS > 1) ? $clog2(WINDOW_PACKETS) : 1;
    localparam int CNT_W = $clog2(WINDOW_PACKETS + 1);
    localparam logic [CNT_W-1:0] FULL    = CNT_W'(WINDOW_PACKETS);
    localparam logic [CNT_W:0]   FULL_X  = (CNT_W + 1)'(WINDOW_PACKETS);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(WINDOW_PACKETS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PR_RD, ST_PR_CHK, ST_PK_RD, ST_PK_WR, ST_TK_DIV, ST_TK_WAIT,
        ST_PCT, ST_PCT_WAIT, ST_BOUND, ST_AGE, ST_REPORT
    } state_t;

    state_t state_reg;

    // configuration
    logic        by_time_reg;
    logic [15:0] win_len_reg;
    logic [15:0] min_bad_reg;
    logic [6:0]  thr_cfg_reg;
    logic [7:0]  wins_reg;
    logic [15:0] hold_reg;
    logic [15:0] gap_reg;
    logic        group_ok_reg;

    // detector state
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] ins_reg;
    logic [CNT_W-1:0] bad_reg;
    logic [31:0]      win_begin_reg;
    logic [1:0]       level_reg;
    logic [7:0]       streak_reg;
    logic [31:0]      changed_at_reg;
    logic             alarm_reg;
    logic [31:0]      alarm_at_reg;
    logic [31:0]      last_reco_reg;

    // current event
    logic [1:0]  func_reg;
    logic        good_reg;
    logic [31:0] now_reg;
    logic [6:0]  pct_reg;
    logic        bound_reg;

    // output beat
    logic        m_valid_reg;
    logic [1:0]  o_level_reg;
    logic [6:0]  o_score_reg;
    logic [6:0]  o_conf_reg;
    logic [7:0]  o_hint_reg;
    logic        o_reco_reg;
    logic        o_fired_reg;
    logic        o_group_reg;

    logic [15:0] dur;
    logic [15:0] gap;
    logic [7:0]  wins;
    logic [6:0]  thr;
    logic [31:0] cutoff;
    logic [31:0] elapsed;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_red;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] ins_next;
    logic [CNT_W-1:0] count_after;
    logic [CNT_W+6:0] bad_x100;
    logic [6:0]  score;
    logic        jammy;
    logic [7:0]  streak_inc;
    logic [6:0]  over;
    logic [CNT_W-1:0] base_full;
    logic [6:0]  base;
    logic [7:0]  conf_sum;
    logic [6:0]  conf;
    logic [7:0]  sus_sum;
    logic [6:0]  sus_lvl;
    logic        reco;
    logic        fired;
    logic        group;
    logic        out_free;

    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [32:0]       ram_rdata;
    logic              rd_good;
    logic [31:0]       rd_time;

    jdha_pkg::div_req_t div_req;
    jdha_pkg::div_rsp_t div_rsp;

    assign dur  = (win_len_reg == 16'd0) ? jdha_pkg::DFLT_WIN_LEN : win_len_reg;
    assign gap  = (gap_reg == 16'd0) ? jdha_pkg::DFLT_RECO_GAP : gap_reg;
    assign wins = (wins_reg == 8'd0) ? 8'd1 : wins_reg;
    assign thr  = jdha_pkg::eff_thr(thr_cfg_reg);

    assign cutoff  = (now_reg > {16'd0, dur}) ? now_reg - {16'd0, dur} : 32'd0;
    assign elapsed = now_reg - win_begin_reg;

    // oldest entry sits count places behind the insert position
    assign tail_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, ins_reg} + FULL_X - {1'b0, count_reg};
    assign tail_red = (tail_sum >= FULL_X) ? tail_sum - FULL_X : tail_sum;
    assign tail     = tail_red[IDX_W-1:0];
    assign ins_next = (ins_reg == LAST_IX) ? '0 : ins_reg + IDX_W'(1);
    assign count_after = (count_reg == FULL) ? count_reg : count_reg + CNT_W'(1);

    assign bad_x100 = {bad_reg, 7'd0} - {2'd0, bad_reg, 5'd0} + {5'd0, bad_reg, 2'd0};

    assign rd_good = ram_rdata[32];
    assign rd_time = ram_rdata[31:0];

    assign score = jdha_pkg::score_of(pct_reg, alarm_reg, count_reg != '0);
    assign jammy = (32'(bad_reg) >= 32'(min_bad_reg)) && (score >= thr);
    assign streak_inc = (streak_reg == jdha_pkg::STREAK_MAX) ? streak_reg : streak_reg + 8'd1;

    assign over      = (score > thr) ? score - thr : 7'd0;
    assign base_full = (32'(count_reg) > 32'(jdha_pkg::PCT_MAX)) ?
                       CNT_W'(jdha_pkg::PCT_MAX) : count_reg;
    assign base      = 7'(base_full >> 1);
    assign conf_sum  = {1'b0, base} + {1'b0, over};
    assign conf      = (count_reg == '0) ? 7'd0 :
                       (conf_sum > {1'b0, jdha_pkg::PCT_MAX}) ? jdha_pkg::PCT_MAX : conf_sum[6:0];
    assign sus_sum   = {1'b0, thr} + {1'b0, jdha_pkg::ALARM_BONUS};
    assign sus_lvl   = (sus_sum > {1'b0, jdha_pkg::PCT_MAX}) ? jdha_pkg::PCT_MAX : sus_sum[6:0];
    assign reco      = ((now_reg - last_reco_reg) >= {16'd0, gap}) &&
                       ((level_reg == jdha_pkg::LVL_JAMMED) ||
                        ((level_reg == jdha_pkg::LVL_SUSPECT) && (score >= sus_lvl)));
    assign fired     = reco && ((func_reg == jdha_pkg::FN_PACKET) ||
                                (func_reg == jdha_pkg::FN_ALARM));
    assign group     = fired && group_ok_reg && ((score >= jdha_pkg::GROUP_SCORE) || alarm_reg);
    assign out_free  = !m_valid_reg || m_ready;

    assign ram_we    = (state_reg == ST_PK_WR);
    assign ram_re    = (state_reg == ST_PR_RD) || (state_reg == ST_PK_RD);
    assign ram_raddr = (state_reg == ST_PK_RD) ? ins_reg : tail;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = 32'(bad_x100);
        div_req.divisor  = 32'(count_reg);
        if (state_reg == ST_TK_DIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = elapsed;
            div_req.divisor  = {16'd0, dur};
        end else if (state_reg == ST_PCT) begin
            div_req.start = (count_reg != '0);
        end
    end

    jdha_ram #(
        .WIDTH (33),
        .DEPTH (WINDOW_PACKETS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ins_reg),
        .wr_data ({good_reg, now_reg}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    jdha_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            by_time_reg  <= 1'b0;
            win_len_reg  <= jdha_pkg::DFLT_WIN_LEN;
            min_bad_reg  <= 16'd0;
            thr_cfg_reg  <= 7'd50;
            wins_reg     <= 8'd1;
            hold_reg     <= 16'd0;
            gap_reg      <= jdha_pkg::DFLT_RECO_GAP;
            group_ok_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                jdha_pkg::REG_WIN_BY_TIME: by_time_reg  <= cfg_wdata[0];
                jdha_pkg::REG_WIN_LEN:     win_len_reg  <= cfg_wdata;
                jdha_pkg::REG_MIN_BAD:     min_bad_reg  <= cfg_wdata;
                jdha_pkg::REG_THRESHOLD:   thr_cfg_reg  <= cfg_wdata[6:0];
                jdha_pkg::REG_WINS_TO_JAM: wins_reg     <= cfg_wdata[7:0];
                jdha_pkg::REG_JAM_HOLD:    hold_reg     <= cfg_wdata;
                jdha_pkg::REG_RECO_GAP:    gap_reg      <= cfg_wdata;
                jdha_pkg::REG_GROUP_OK:    group_ok_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ins_reg        <= '0;
            bad_reg        <= '0;
            win_begin_reg  <= '0;
            level_reg      <= jdha_pkg::LVL_CLEAR;
            streak_reg     <= '0;
            changed_at_reg <= '0;
            alarm_reg      <= 1'b0;
            alarm_at_reg   <= '0;
            last_reco_reg  <= '0;
            bound_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_REPORT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        good_reg  <= s_packet_good;
                        now_reg   <= s_time_ms;
                        bound_reg <= 1'b0;
                        if (s_func == jdha_pkg::FN_ALARM) begin
                            alarm_reg    <= 1'b1;
                            alarm_at_reg <= s_time_ms;
                        end
                        priority if (s_func == jdha_pkg::FN_PACKET) begin
                            state_reg <= by_time_reg ? ST_PR_RD : ST_PK_RD;
                        end else if (s_func == jdha_pkg::FN_ALARM ||
                                     s_func == jdha_pkg::FN_TICK) begin
                            state_reg <= by_time_reg ? ST_PR_RD : ST_PCT;
                        end else begin
                            state_reg <= ST_PCT;
                        end
                    end
                end
                ST_PR_RD: begin
                    if (count_reg != '0) begin
                        state_reg <= ST_PR_CHK;
                    end else begin
                        priority if (func_reg == jdha_pkg::FN_PACKET) begin
                            state_reg <= ST_PK_RD;
                        end else if (func_reg == jdha_pkg::FN_TICK &&
                                     elapsed >= {16'd0, dur}) begin
                            state_reg <= ST_TK_DIV;
                        end else begin
                            state_reg <= ST_PCT;
                        end
                    end
                end
                ST_PR_CHK: begin
                    if (rd_time >= cutoff) begin
                        priority if (func_reg == jdha_pkg::FN_PACKET) begin
                            state_reg <= ST_PK_RD;
                        end else if (func_reg == jdha_pkg::FN_TICK &&
                                     elapsed >= {16'd0, dur}) begin
                            state_reg <= ST_TK_DIV;
                        end else begin
                            state_reg <= ST_PCT;
                        end
                    end else begin
                        if (!rd_good && bad_reg != '0) begin
                            bad_reg <= bad_reg - CNT_W'(1);
                        end
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_PR_RD;
                    end
                end
                ST_PK_RD: begin
                    state_reg <= ST_PK_WR;
                end
                ST_PK_WR: begin
                    // overwriting the oldest entry of a full ring drops its bad mark
                    if (count_reg == FULL) begin
                        if (!rd_good && bad_reg != '0) begin
                            bad_reg <= good_reg ? bad_reg - CNT_W'(1) : bad_reg;
                        end else begin
                            bad_reg <= good_reg ? bad_reg : bad_reg + CNT_W'(1);
                        end
                    end else begin
                        bad_reg <= good_reg ? bad_reg : bad_reg + CNT_W'(1);
                    end
                    count_reg <= count_after;
                    ins_reg   <= ins_next;
                    bound_reg <= !by_time_reg && (count_after == FULL) && (ins_next == '0);
                    state_reg <= ST_PCT;
                end
                ST_TK_DIV: begin
                    state_reg <= ST_TK_WAIT;
                end
                ST_TK_WAIT: begin
                    if (div_rsp.done) begin
                        win_begin_reg <= win_begin_reg + (elapsed - div_rsp.rem);
                        bound_reg     <= 1'b1;
                        state_reg     <= ST_PCT;
                    end
                end
                ST_PCT: begin
                    if (count_reg == '0) begin
                        pct_reg   <= 7'd0;
                        state_reg <= bound_reg ? ST_BOUND : ST_AGE;
                    end else begin
                        state_reg <= ST_PCT_WAIT;
                    end
                end
                ST_PCT_WAIT: begin
                    if (div_rsp.done) begin
                        pct_reg   <= div_rsp.quot[6:0];
                        state_reg <= bound_reg ? ST_BOUND : ST_AGE;
                    end
                end
                ST_BOUND: begin
                    if (jammy) begin
                        streak_reg <= streak_inc;
                        if (streak_inc >= wins) begin
                            if (level_reg != jdha_pkg::LVL_JAMMED) begin
                                level_reg      <= jdha_pkg::LVL_JAMMED;
                                changed_at_reg <= now_reg;
                            end
                        end else if (level_reg == jdha_pkg::LVL_CLEAR) begin
                            level_reg      <= jdha_pkg::LVL_SUSPECT;
                            changed_at_reg <= now_reg;
                        end
                    end else begin
                        streak_reg <= '0;
                        if (level_reg == jdha_pkg::LVL_JAMMED) begin
                            if ((now_reg - changed_at_reg) >= {16'd0, hold_reg}) begin
                                level_reg      <= jdha_pkg::LVL_SUSPECT;
                                changed_at_reg <= now_reg;
                            end
                        end else if (level_reg == jdha_pkg::LVL_SUSPECT) begin
                            if (count_reg == '0 || score < (thr >> 1)) begin
                                level_reg      <= jdha_pkg::LVL_CLEAR;
                                changed_at_reg <= now_reg;
                            end
                        end
                    end
                    state_reg <= ST_AGE;
                end
                ST_AGE: begin
                    // alarms only age out on ticks
                    if (func_reg == jdha_pkg::FN_TICK && alarm_reg &&
                        (now_reg - alarm_at_reg) >=
                        (by_time_reg ? {16'd0, dur} : jdha_pkg::ALARM_AGE_CNT)) begin
                        alarm_reg <= 1'b0;
                    end
                    state_reg <= ST_REPORT;
                end
                ST_REPORT: begin
                    if (out_free) begin
                        o_level_reg <= level_reg;
                        o_score_reg <= score;
                        o_conf_reg  <= conf;
                        o_hint_reg  <= jdha_pkg::hint_of(score);
                        o_reco_reg  <= reco;
                        o_fired_reg <= fired;
                        o_group_reg <= group;
                        if (fired) begin
                            last_reco_reg <= now_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_link_state     = o_level_reg;
    assign m_score          = o_score_reg;
    assign m_confidence     = o_conf_reg;
    assign m_aggressiveness = o_hint_reg;
    assign m_hop_advice     = o_reco_reg;
    assign m_hop_fired      = o_fired_reg;
    assign m_group_switch   = o_group_reg;

`ifndef SYNTHESIS
    a_count_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL) else $error("ring fill beyond depth");
    a_bad_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        bad_reg <= count_reg) else $error("bad count exceeds ring fill");
    a_fired_has_reco: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hop_fired |-> m_hop_advice) else $error("hop fired without reco");
    a_group_has_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_group_switch |-> m_hop_fired) else $error("group switch without hop");
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_TK_WAIT || state_reg == ST_PCT_WAIT))
        else $error("divider result with nobody waiting");
`endif

endmodule
`default_nettype wire

@@ dv/jamming_detector_hop_advisor_checker.sv @@
`timescale 1ns / 100ps
module jamming_detector_hop_advisor_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic               s_packet_good,
    input  logic [31:0]        s_time_ms,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_link_state,
    input  logic [6:0]         m_score,
    input  logic [6:0]         m_confidence,
    input  logic [7:0]         m_aggressiveness,
    input  logic               m_hop_advice,
    input  logic               m_hop_fired,
    input  logic               m_group_switch,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output int unsigned        fail_count,
    output int unsigned        outstanding
);

    localparam int unsigned RING_DEPTH = 64;

    typedef struct packed {
        logic [1:0] level;
        logic [6:0] score;
        logic [6:0] confidence;
        logic [7:0] aggressiveness;
        logic       recommend;
        logic       fired;
        logic       group;
    } hop_report_t;

    hop_report_t report_q[$];

    // register copies
    int unsigned by_time, win_ms, min_bad, thr_pct, wins_needed, hold_ms, gap_ms, group_ok;

    // detector state
    logic        ring_ok [RING_DEPTH];
    logic [31:0] ring_ms [RING_DEPTH];
    int unsigned fill, wr_pos, bad_cnt, win_start, level, streak, level_at;
    int unsigned alarm_live, alarm_ms, last_hop_ms;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic int unsigned win_len();
        return (win_ms != 0) ? win_ms : 1000;
    endfunction

    function automatic int unsigned hop_gap();
        return (gap_ms != 0) ? gap_ms : 500;
    endfunction

    function automatic int unsigned thr_eff();
        if (thr_pct < 1) return 1;
        if (thr_pct > 100) return 100;
        return thr_pct;
    endfunction

    function automatic void clear_state();
        by_time = 0; win_ms = 1000; min_bad = 0; thr_pct = 50;
        wins_needed = 1; hold_ms = 0; gap_ms = 500; group_ok = 0;
        fill = 0; wr_pos = 0; bad_cnt = 0; win_start = 0;
        level = jdha_pkg::LVL_CLEAR; streak = 0; level_at = 0;
        alarm_live = 0; alarm_ms = 0; last_hop_ms = 0;
    endfunction

    // plain unsigned cutoff, not wrapped
    function automatic void age_out(int unsigned now_ms);
        int unsigned cutoff, tail;
        if (by_time == 0) return;
        cutoff = (now_ms > win_len()) ? now_ms - win_len() : 0;
        while (fill > 0) begin
            tail = (wr_pos + RING_DEPTH - fill) % RING_DEPTH;
            if (ring_ms[tail] >= cutoff) break;
            if (!ring_ok[tail] && bad_cnt > 0) bad_cnt--;
            fill--;
        end
    endfunction

    function automatic int unsigned bad_score();
        int unsigned pct;
        if (fill == 0) return 0;
        pct = bad_cnt * 100 / fill;
        if (alarm_live != 0) begin
            pct += 10;
            if (pct > 100) pct = 100;
        end
        return pct;
    endfunction

    function automatic void close_window(int unsigned now_ms);
        int unsigned sc;
        bit jammy;
        sc    = bad_score();
        jammy = (bad_cnt >= min_bad) && (sc >= thr_eff());
        if (jammy) begin
            if (streak < 255) streak++;
            if (streak >= ((wins_needed != 0) ? wins_needed : 1)) begin
                if (level != jdha_pkg::LVL_JAMMED) begin
                    level = jdha_pkg::LVL_JAMMED;
                    level_at = now_ms;
                end
            end else if (level == jdha_pkg::LVL_CLEAR) begin
                level = jdha_pkg::LVL_SUSPECT;
                level_at = now_ms;
            end
        end else begin
            streak = 0;
            if (level == jdha_pkg::LVL_JAMMED) begin
                if (now_ms - level_at >= hold_ms) begin
                    level = jdha_pkg::LVL_SUSPECT;
                    level_at = now_ms;
                end
            end else if (level == jdha_pkg::LVL_SUSPECT) begin
                if (fill == 0 || sc < thr_eff() / 2) begin
                    level = jdha_pkg::LVL_CLEAR;
                    level_at = now_ms;
                end
            end
        end
    endfunction

    function automatic hop_report_t assess_event(logic [1:0] fn, logic good, int unsigned now_ms);
        hop_report_t r;
        int unsigned sc, conf, over, base, elapsed, limit, sus;
        bit reco;
        conf = 0;
        reco = 0;
        if (fn == jdha_pkg::FN_PACKET) begin
            age_out(now_ms);
            if (fill == RING_DEPTH) begin
                if (!ring_ok[wr_pos] && bad_cnt > 0) bad_cnt--;
            end else begin
                fill++;
            end
            ring_ok[wr_pos] = good;
            ring_ms[wr_pos] = now_ms;
            if (!good) bad_cnt++;
            wr_pos = (wr_pos + 1) % RING_DEPTH;
            if (by_time == 0 && fill == RING_DEPTH && wr_pos == 0) close_window(now_ms);
        end else if (fn == jdha_pkg::FN_ALARM) begin
            alarm_live = 1;
            alarm_ms = now_ms;
            age_out(now_ms);
        end else if (fn == jdha_pkg::FN_TICK) begin
            if (by_time != 0) begin
                age_out(now_ms);
                elapsed = now_ms - win_start;
                if (elapsed >= win_len()) begin
                    win_start += (elapsed / win_len()) * win_len();
                    close_window(now_ms);
                end
            end
            if (alarm_live != 0) begin
                limit = (by_time != 0) ? win_len() : 1000;
                if (now_ms - alarm_ms >= limit) alarm_live = 0;
            end
        end
        sc = bad_score();
        if (fill > 0) begin
            over = (sc > thr_eff()) ? sc - thr_eff() : 0;
            base = (fill > 100) ? 100 : fill;
            conf = base / 2 + over;
            if (conf > 100) conf = 100;
        end
        if (now_ms - last_hop_ms >= hop_gap()) begin
            sus = thr_eff() + 10;
            if (sus > 100) sus = 100;
            if (level == jdha_pkg::LVL_JAMMED) reco = 1;
            else if (level == jdha_pkg::LVL_SUSPECT && sc >= sus) reco = 1;
        end
        r.level          = level[1:0];
        r.score          = sc[6:0];
        r.confidence     = conf[6:0];
        r.aggressiveness = 8'(sc * 255 / 100);
        r.recommend      = reco;
        r.fired          = 1'b0;
        r.group          = 1'b0;
        if (reco && (fn == jdha_pkg::FN_PACKET || fn == jdha_pkg::FN_ALARM)) begin
            r.fired = 1'b1;
            r.group = (group_ok != 0) && (sc >= 80 || alarm_live != 0);
            last_hop_ms = now_ms;
        end
        return r;
    endfunction

    function automatic void report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        hop_report_t want;
        int unsigned pushed, popped;
        pushed = 0;
        popped = 0;
        if (!aresetn) begin
            clear_state();
            report_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    jdha_pkg::REG_WIN_BY_TIME: by_time     = cfg_wdata[0];
                    jdha_pkg::REG_WIN_LEN:     win_ms      = cfg_wdata;
                    jdha_pkg::REG_MIN_BAD:     min_bad     = cfg_wdata;
                    jdha_pkg::REG_THRESHOLD:   thr_pct     = cfg_wdata[6:0];
                    jdha_pkg::REG_WINS_TO_JAM: wins_needed = cfg_wdata[7:0];
                    jdha_pkg::REG_JAM_HOLD:    hold_ms     = cfg_wdata;
                    jdha_pkg::REG_RECO_GAP:    gap_ms      = cfg_wdata;
                    jdha_pkg::REG_GROUP_OK:    group_ok    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                report_q.push_back(assess_event(s_func, s_packet_good, s_time_ms));
                pushed = 1;
            end
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual state %0d score %0d",
                             $time, m_link_state, m_score);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    popped = 1;
                    report_field("link_state", want.level, m_link_state);
                    report_field("score", want.score, m_score);
                    report_field("confidence", want.confidence, m_confidence);
                    report_field("aggressiveness", want.aggressiveness, m_aggressiveness);
                    report_field("hop_advice", want.recommend, m_hop_advice);
                    report_field("hop_fired", want.fired, m_hop_fired);
                    report_field("group_switch", want.group, m_group_switch);
                end
            end
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

@@ dv/jamming_detector_hop_advisor_unit_tb.sv @@
`timescale 1ns / 100ps
module jamming_detector_hop_advisor_unit_tb;

    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 190;
    // event kind with no meaning, must leave the state alone
    localparam logic [1:0] FN_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = jdha_pkg::FN_PACKET;
    logic        s_packet_good = 1'b0;
    logic [31:0] s_time_ms = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_link_state;
    logic [6:0]  m_score;
    logic [6:0]  m_confidence;
    logic [7:0]  m_aggressiveness;
    logic        m_hop_advice;
    logic        m_hop_fired;
    logic        m_group_switch;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = jdha_pkg::REG_WIN_BY_TIME;
    logic [15:0] cfg_wdata = 16'd0;

    int unsigned fail_count;
    int unsigned outstanding;
    bit          stalls_on = 1'b1;
    int          ready_hold = 0;
    logic [31:0] now_ms = 32'd0;
    int unsigned step_max;
    int unsigned bad_bias;

    jamming_detector_hop_advisor_unit i_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_func, .s_packet_good, .s_time_ms,
        .m_valid, .m_ready, .m_link_state, .m_score, .m_confidence, .m_aggressiveness,
        .m_hop_advice, .m_hop_fired, .m_group_switch,
        .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    jamming_detector_hop_advisor_checker i_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_func, .s_packet_good, .s_time_ms,
        .m_valid, .m_ready, .m_link_state, .m_score, .m_confidence, .m_aggressiveness,
        .m_hop_advice, .m_hop_fired, .m_group_switch,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .fail_count, .outstanding
    );

    always #2 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("FAIL jamming_detector_hop_advisor_unit");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (!stalls_on) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= !m_ready;
            ready_hold <= m_ready ? $urandom_range(0, 9) : $urandom_range(0, 40);
        end
    end

    task automatic send_event(logic [1:0] fn, logic good, logic [31:0] at_ms);
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_packet_good <= good;
        s_time_ms     <= at_ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // wait for every result, then leave the inputs idle before going on
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_phase(int p);
        logic [15:0] v [8];
        case (p)
            0: v = '{16'd0, 16'd1000, 16'd0, 16'd50, 16'd1, 16'd0, 16'd500, 16'd1};
            1: v = '{16'd1, 16'd50, 16'd3, 16'd30, 16'd2, 16'd100, 16'd20, 16'd1};
            // zeros take their fallback values
            2: v = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            3: v = '{16'd0, 16'd65535, 16'd65535, 16'd127, 16'd255, 16'd65535, 16'd65535,
                     16'd1};
            4: v = '{16'd1, 16'd65535, 16'd1, 16'd100, 16'd255, 16'd65535, 16'd1, 16'd1};
            5: v = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1};
            6: v = '{16'd0, 16'd1, 16'd10, 16'd101, 16'd3, 16'd5, 16'd1, 16'd0};
            default: begin
                v[0] = 16'($urandom_range(0, 1));
                v[1] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(1, 300));
                v[2] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 20));
                v[3] = 16'($urandom_range(0, 127));
                v[4] = 16'($urandom_range(0, 255) >> $urandom_range(0, 7));
                v[5] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 400));
                v[6] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 200));
                v[7] = 16'($urandom_range(0, 1));
            end
        endcase
        write_reg(jdha_pkg::REG_WIN_BY_TIME, v[0]);
        write_reg(jdha_pkg::REG_WIN_LEN, v[1]);
        write_reg(jdha_pkg::REG_MIN_BAD, v[2]);
        write_reg(jdha_pkg::REG_THRESHOLD, v[3]);
        write_reg(jdha_pkg::REG_WINS_TO_JAM, v[4]);
        write_reg(jdha_pkg::REG_JAM_HOLD, v[5]);
        write_reg(jdha_pkg::REG_RECO_GAP, v[6]);
        write_reg(jdha_pkg::REG_GROUP_OK, v[7]);
        cfg_wr_en <= 1'b0;
        if (v[0][0])
            step_max = ((v[1] == 0) ? 1000 : v[1]) / 10 + 3;
        else
            step_max = $urandom_range(5, 60);
        if (p == 5) now_ms = 32'hFFFF_FF00;
    endtask

    initial begin
        logic [1:0] fn;
        int unsigned pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset config, count windows
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'd0);
        send_event(jdha_pkg::FN_PACKET, 1'b1, 32'd0);
        send_event(jdha_pkg::FN_ALARM, 1'b1, 32'd5);
        send_event(jdha_pkg::FN_TICK, 1'b1, 32'd10);
        send_event(jdha_pkg::FN_TICK, 1'b0, 32'd500);
        send_event(FN_SPARE, 1'b1, 32'd600);
        send_event(FN_SPARE, 1'b0, 32'hFFFF_FFFF);
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'd700);
        send_event(jdha_pkg::FN_ALARM, 1'b0, 32'd800);
        send_event(jdha_pkg::FN_TICK, 1'b0, 32'd1005);
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'hFFFF_FFFF);
        send_event(jdha_pkg::FN_PACKET, 1'b1, 32'hAAAA_5555);
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'h5555_AAAA);
        send_event(jdha_pkg::FN_ALARM, 1'b1, 32'hFFFF_FFF0);
        send_event(jdha_pkg::FN_TICK, 1'b1, 32'd3);
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'd2000);
        send_event(jdha_pkg::FN_PACKET, 1'b0, 32'd2600);
        send_event(jdha_pkg::FN_TICK, 1'b1, 32'd0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_phase(p);
            if (p == PHASES - 1) stalls_on = 1'b0;
            bad_bias = $urandom_range(0, 100);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) settle();
                if (n % 30 == 0) bad_bias = $urandom_range(0, 100);
                pick = $urandom_range(0, 99);
                if (pick < 70) fn = jdha_pkg::FN_PACKET;
                else if (pick < 80) fn = jdha_pkg::FN_ALARM;
                else if (pick < 98) fn = jdha_pkg::FN_TICK;
                else fn = FN_SPARE;
                pick = $urandom_range(0, 49);
                if (pick == 0) now_ms = $urandom;
                else if (pick == 1) now_ms = now_ms - $urandom_range(0, step_max);
                else now_ms = now_ms + $urandom_range(0, step_max);
                send_event(fn, $urandom_range(0, 99) >= bad_bias, now_ms);
            end
        end
        settle();

        if (fail_count == 0)
            $display("PASS jamming_detector_hop_advisor_unit");
        else
            $display("FAIL jamming_detector_hop_advisor_unit");
        $finish;
    end

endmodule

@@ jamming_detector_hop_advisor_unit.f @@
sv/jdha_pkg.sv
sv/jdha_ram.sv
sv/jdha_div.sv
sv/jamming_detector_hop_advisor_unit.sv
dv/jamming_detector_hop_advisor_checker.sv
dv/jamming_detector_hop_advisor_unit_tb.sv
